@@ rtl/ray_box_hit_test_macros.svh @@
// ----------------------------------------------------------------------------
// Ray box hit test assertion macros
// Implication and next-cycle checks, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_HIT_TEST_MACROS_SVH
`define RAY_BOX_HIT_TEST_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RBHT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbht: implication check failed");
// next-cycle implication
`define RBHT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbht: next-cycle check failed");
`else
`define RBHT_ASSERT_IMP(label, clk, rst, ante, cons)
`define RBHT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/rbht_pkg.sv @@
// ----------------------------------------------------------------------------
// Ray box hit test package
// Widths, register indexes and payload types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none
package rbht_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int RANGE_WIDTH = COORD_WIDTH - 1;
   localparam int CSR_INDEX_W = 3;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // register indexes
   localparam csr_index_type CSR_ORIGIN_X    = 3'd0;
   localparam csr_index_type CSR_ORIGIN_Y    = 3'd1;
   localparam csr_index_type CSR_ORIGIN_Z    = 3'd2;
   localparam csr_index_type CSR_DIRECTION_X = 3'd3;
   localparam csr_index_type CSR_DIRECTION_Y = 3'd4;
   localparam csr_index_type CSR_DIRECTION_Z = 3'd5;
   localparam csr_index_type CSR_RANGE       = 3'd6;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] box_min_x;
      logic signed [COORD_WIDTH-1:0] box_max_x;
      logic signed [COORD_WIDTH-1:0] box_min_y;
      logic signed [COORD_WIDTH-1:0] box_max_y;
      logic signed [COORD_WIDTH-1:0] box_min_z;
      logic signed [COORD_WIDTH-1:0] box_max_z;
   } box_type;

   typedef struct packed {
      logic                          box_hit;
      logic signed [COORD_WIDTH-1:0] entry_distance;
   } rsp_type;

   // side information of one slab quotient
   typedef struct packed {
      logic qneg;   // quotient negative
      logic dzero;  // direction is zero
      logic nneg;   // numerator negative
   } div_flags_type;

endpackage
`default_nettype wire

@@ rtl/ray_box_hit_test.sv @@
// ----------------------------------------------------------------------------
// Ray box hit test
// Slab test of streamed axis-aligned boxes against a ray held in registers.
// ----------------------------------------------------------------------------
// One box enters per cycle and one result leaves per cycle unless req_stall
// or rsp_stall holds the flow. The six slab dividers produce one quotient
// bit per stage, which sets the depth, followed by a saturation stage, a
// six-round odd-even sort, a midpoint stage, a multiply stage and the
// output register. A two-entry output buffer keeps the pipe moving while a
// result waits on rsp_stall; the input stalls only once a second result has
// landed in the skid entry.
// Ray registers may only be written while no box is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_box_hit_test_macros.svh"
module ray_box_hit_test #(
   parameter int FRAC_BITS = rbht_pkg::FRAC_BITS
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire rbht_pkg::box_type         req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output rbht_pkg::rsp_type              rsp_data,
   input  wire                            csr_we,
   input  wire rbht_pkg::csr_index_type   csr_index,
   input  wire logic [rbht_pkg::COORD_WIDTH-1:0] csr_wdata
);

   localparam int W     = rbht_pkg::COORD_WIDTH;
   localparam int QW    = W + 1 + FRAC_BITS;
   localparam int DS    = QW + 1;
   localparam int SATS  = DS;
   localparam int MIDS  = SATS + 7;
   localparam int MULS  = SATS + 8;
   localparam int NP    = MULS + 1;

   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [QW-1:0] QMAX = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [QW-1:0] QMIN = QMAX + QW'(1);

   // ray registers
   logic signed [W-1:0]             org_ff [3];
   logic signed [W-1:0]             dir_ff [3];
   logic [rbht_pkg::RANGE_WIDTH-1:0] rng_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= W'(1) << FRAC_BITS;
         dir_ff[1] <= '0;
         dir_ff[2] <= '0;
         rng_ff    <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            rbht_pkg::CSR_ORIGIN_X:    org_ff[0] <= csr_wdata;
            rbht_pkg::CSR_ORIGIN_Y:    org_ff[1] <= csr_wdata;
            rbht_pkg::CSR_ORIGIN_Z:    org_ff[2] <= csr_wdata;
            rbht_pkg::CSR_DIRECTION_X: dir_ff[0] <= csr_wdata;
            rbht_pkg::CSR_DIRECTION_Y: dir_ff[1] <= csr_wdata;
            rbht_pkg::CSR_DIRECTION_Z: dir_ff[2] <= csr_wdata;
            rbht_pkg::CSR_RANGE:       rng_ff    <= csr_wdata[rbht_pkg::RANGE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control: every stage moves while the output buffer has room
   logic           adv;
   logic [NP-1:0]  v_ff;
   logic           out_v_ff, skid_v_ff;
   rbht_pkg::rsp_type out_ff, skid_ff;

   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NP-2:0], req_valid};
      end
   end

   // box bounds travel beside the arithmetic
   rbht_pkg::box_type bx_ff [0:MULS];

   always_ff @(posedge clock) begin
      if (adv) begin
         bx_ff[0] <= req_data;
      end
   end

   for (genvar k = 1; k <= MULS; k++) begin : g_box
      always_ff @(posedge clock) begin
         if (adv) begin
            bx_ff[k] <= bx_ff[k-1];
         end
      end
   end

   // six slab dividers
   logic signed [W-1:0]      bnd [6];
   logic [QW-1:0]            quot [6];
   rbht_pkg::div_flags_type  dflg [6];

   assign bnd[0] = req_data.box_min_x;
   assign bnd[1] = req_data.box_max_x;
   assign bnd[2] = req_data.box_min_y;
   assign bnd[3] = req_data.box_max_y;
   assign bnd[4] = req_data.box_min_z;
   assign bnd[5] = req_data.box_max_z;

   for (genvar i = 0; i < 6; i++) begin : g_div
      rbht_slab_div #(
         .COORD_W (W),
         .FRAC_W  (FRAC_BITS)
      ) u_div (
         .clock (clock),
         .adv   (adv),
         .bound (bnd[i]),
         .org   (org_ff[i/2]),
         .dir   (dir_ff[i/2]),
         .quot  (quot[i]),
         .flags (dflg[i])
      );
   end

   // sign and saturation of the quotients
   logic signed [W-1:0] srt_ff [0:6][6];
   logic signed [W-1:0] sat_in [6];

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         if (dflg[i].dzero) begin
            sat_in[i] = dflg[i].nneg ? SMIN : SMAX;
         end else if (dflg[i].qneg) begin
            sat_in[i] = (quot[i] > QMIN) ? SMIN : W'(-quot[i]);
         end else begin
            sat_in[i] = (quot[i] > QMAX) ? SMAX : quot[i][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         srt_ff[0] <= sat_in;
      end
   end

   // odd-even transposition sort, one round per stage
   for (genvar r = 1; r <= 6; r++) begin : g_sort
      logic signed [W-1:0] nx [6];
      always_comb begin
         nx = srt_ff[r-1];
         for (int p = (r % 2 == 1) ? 0 : 1; p + 1 < 6; p += 2) begin
            if (srt_ff[r-1][p] > srt_ff[r-1][p+1]) begin
               nx[p]   = srt_ff[r-1][p+1];
               nx[p+1] = srt_ff[r-1][p];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            srt_ff[r] <= nx;
         end
      end
   end

   // midpoint of third and fourth smallest, range check
   logic signed [W:0]   msum;
   logic signed [W-1:0] mid_ff, t2_mid_ff, t2_mul_ff;
   logic                rok_mid_ff, rok_mul_ff, rok_in;

   always_comb begin
      msum   = {srt_ff[6][2][W-1], srt_ff[6][2]} + {srt_ff[6][3][W-1], srt_ff[6][3]};
      rok_in = !($signed({2'b00, rng_ff}) < $signed({srt_ff[6][2][W-1], srt_ff[6][2]}));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid_ff     <= msum[W:1];
         t2_mid_ff  <= srt_ff[6][2];
         rok_mid_ff <= rok_in;
      end
   end

   // point along the ray, one product per axis
   logic signed [2*W-1:0] prod_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            prod_ff[a] <= mid_ff * dir_ff[a];
         end
         t2_mul_ff  <= t2_mid_ff;
         rok_mul_ff <= rok_mid_ff;
      end
   end

   // saturated point against the bounds
   logic signed [2*W-1:0] psh [3];
   logic signed [2*W:0]   psum [3];
   logic signed [W-1:0]   pnt [3];
   logic signed [W-1:0]   blo [3], bhi [3];
   logic [2:0]            ins;
   rbht_pkg::rsp_type     fin;

   always_comb begin
      blo[0] = bx_ff[MULS].box_min_x;
      bhi[0] = bx_ff[MULS].box_max_x;
      blo[1] = bx_ff[MULS].box_min_y;
      bhi[1] = bx_ff[MULS].box_max_y;
      blo[2] = bx_ff[MULS].box_min_z;
      bhi[2] = bx_ff[MULS].box_max_z;
      for (int a = 0; a < 3; a++) begin
         psh[a]  = prod_ff[a] >>> FRAC_BITS;
         psum[a] = {psh[a][2*W-1], psh[a]} + (2*W+1)'(org_ff[a]);
         if (psum[a] > (2*W+1)'(SMAX)) begin
            pnt[a] = SMAX;
         end else if (psum[a] < (2*W+1)'(SMIN)) begin
            pnt[a] = SMIN;
         end else begin
            pnt[a] = psum[a][W-1:0];
         end
         ins[a] = (pnt[a] >= blo[a]) && (pnt[a] <= bhi[a]);
      end
      fin.box_hit        = rok_mul_ff && (&ins);
      fin.entry_distance = t2_mul_ff;
   end

   // output register with one skid entry
   logic arr_v, take;

   assign arr_v = v_ff[NP-1] && adv;
   assign take  = out_v_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || take) begin
         out_v_ff  <= skid_v_ff || arr_v;
         skid_v_ff <= 1'b0;
      end else if (arr_v) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || take) begin
         out_ff <= skid_v_ff ? skid_ff : fin;
      end else if (arr_v) begin
         skid_ff <= fin;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   `RBHT_ASSERT_NXT(a_accept_enters, clock, reset, req_valid && !req_stall, v_ff[0])
   `RBHT_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_v_ff, out_v_ff && req_stall)
   `RBHT_ASSERT_IMP(a_hit_in_range, clock, reset, out_v_ff && out_ff.box_hit, !($signed({2'b00, rng_ff}) < $signed({out_ff.entry_distance[W-1], out_ff.entry_distance})))
   `RBHT_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, (v_ff == '0) && !out_v_ff && !skid_v_ff)

endmodule
`default_nettype wire

@@ rtl/rbht_slab_div.sv @@
// ----------------------------------------------------------------------------
// Slab distance divider
// Restoring divider, one quotient bit per stage: |bound - origin| * 2^F / |dir|.
// ----------------------------------------------------------------------------
`default_nettype none
module rbht_slab_div #(
   parameter int COORD_W = rbht_pkg::COORD_WIDTH,
   parameter int FRAC_W  = rbht_pkg::FRAC_BITS
) (
   input  wire                                 clock,
   input  wire                                 adv,
   input  wire logic signed [COORD_W-1:0]      bound,
   input  wire logic signed [COORD_W-1:0]      org,
   input  wire logic signed [COORD_W-1:0]      dir,
   output logic [COORD_W+FRAC_W:0]             quot,
   output rbht_pkg::div_flags_type             flags
);

   localparam int QW = COORD_W + 1 + FRAC_W;

   logic [COORD_W-1:0]        rem_ff  [0:QW];
   logic [QW-1:0]             dq_ff   [0:QW];
   logic [COORD_W-1:0]        dmag_ff [0:QW];
   rbht_pkg::div_flags_type   flg_ff  [0:QW];

   logic signed [COORD_W:0]   num;
   logic [COORD_W:0]          nmag;
   logic [COORD_W-1:0]        dmag;
   rbht_pkg::div_flags_type   flg_in;

   // operand setup
   always_comb begin
      num          = {bound[COORD_W-1], bound} - {org[COORD_W-1], org};
      nmag         = num[COORD_W] ? (COORD_W+1)'(-num) : num;
      dmag         = dir[COORD_W-1] ? COORD_W'(-dir) : dir;
      flg_in.nneg  = num[COORD_W];
      flg_in.dzero = (dir == '0);
      flg_in.qneg  = num[COORD_W] ^ dir[COORD_W-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= '0;
         dq_ff[0]   <= {nmag, {FRAC_W{1'b0}}};
         dmag_ff[0] <= dmag;
         flg_ff[0]  <= flg_in;
      end
   end

   // one quotient bit per stage
   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [COORD_W:0]   tt;
      logic [COORD_W:0]   diff;
      logic               ge;
      logic [COORD_W-1:0] rem_in;

      always_comb begin
         tt     = {rem_ff[k-1], dq_ff[k-1][QW-1]};
         diff   = tt - {1'b0, dmag_ff[k-1]};
         ge     = (tt >= {1'b0, dmag_ff[k-1]});
         rem_in = ge ? diff[COORD_W-1:0] : tt[COORD_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            dq_ff[k]   <= {dq_ff[k-1][QW-2:0], ge};
            dmag_ff[k] <= dmag_ff[k-1];
            flg_ff[k]  <= flg_ff[k-1];
         end
      end
   end

   assign quot  = dq_ff[QW];
   assign flags = flg_ff[QW];

endmodule
`default_nettype wire

@@ dv/tb_ray_box_hit_test.sv @@
// ----------------------------------------------------------------------------
// Ray box hit test testbench
// Streams boxes against a sequence of ray setups and checks each hit flag and
// entry distance against an in-bench slab predictor, under random idling.
// ----------------------------------------------------------------------------
`default_nettype none

// Holds the ray setup, predicts each box's result and checks the results.
class hit_scoreboard;
   longint org[3];
   longint dir[3];
   longint range_lim;
   rbht_pkg::rsp_type hits_due[$];
   int fails;

   function new();
      fails = 0;
      reset_ray();
   endfunction

   function void reset_ray();
      org = '{0, 0, 0};
      dir = '{65536, 0, 0};
      range_lim = 64'h7FFF_FFFF;
   endfunction

   function void write_reg(rbht_pkg::csr_index_type idx, logic [31:0] val);
      longint sv;
      sv = longint'(signed'(val));
      case (idx)
         rbht_pkg::CSR_ORIGIN_X: org[0] = sv;
         rbht_pkg::CSR_ORIGIN_Y: org[1] = sv;
         rbht_pkg::CSR_ORIGIN_Z: org[2] = sv;
         rbht_pkg::CSR_DIRECTION_X: dir[0] = sv;
         rbht_pkg::CSR_DIRECTION_Y: dir[1] = sv;
         rbht_pkg::CSR_DIRECTION_Z: dir[2] = sv;
         rbht_pkg::CSR_RANGE: range_lim = longint'(val[30:0]);
         default: ;
      endcase
   endfunction

   static function longint clamp32(longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
   endfunction

   static function longint slab_dist(longint bound, longint o, longint d);
      longint num;
      num = bound - o;
      if (d == 0) return (num < 0) ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
      return clamp32((num * 65536) / d);
   endfunction

   // test point on one axis against its bounds, inclusive
   static function bit on_axis(longint o, longint d, longint t, longint lo, longint hi);
      longint p;
      p = clamp32(o + ((t * d) >>> 16));
      return (p >= lo) && (p <= hi);
   endfunction

   function void note_box(rbht_pkg::box_type b);
      longint bnd[6];
      longint t[6];
      longint v, mid;
      int j;
      rbht_pkg::rsp_type r;
      bnd = '{longint'(b.box_min_x), longint'(b.box_max_x), longint'(b.box_min_y),
              longint'(b.box_max_y), longint'(b.box_min_z), longint'(b.box_max_z)};
      for (int i = 0; i < 6; i++) t[i] = slab_dist(bnd[i], org[i/2], dir[i/2]);
      for (int i = 1; i < 6; i++) begin
         v = t[i];
         j = i;
         while (j > 0 && t[j-1] > v) begin
            t[j] = t[j-1];
            j--;
         end
         t[j] = v;
      end
      mid = (t[2] + t[3]) >>> 1;
      r.box_hit = !(range_lim < t[2]) &&
                  on_axis(org[0], dir[0], mid, bnd[0], bnd[1]) &&
                  on_axis(org[1], dir[1], mid, bnd[2], bnd[3]) &&
                  on_axis(org[2], dir[2], mid, bnd[4], bnd[5]);
      r.entry_distance = t[2][31:0];
      hits_due.insert(hits_due.size(), r);
   endfunction

   function void check_result(rbht_pkg::rsp_type got);
      rbht_pkg::rsp_type want;
      if (hits_due.size() == 0) begin
         $error("unexpected result: box_hit %0d entry_distance %0d",
                got.box_hit, got.entry_distance);
         fails++;
         return;
      end
      want = hits_due.pop_front();
      if (got.box_hit !== want.box_hit) begin
         $error("box_hit: expected %0d, actual %0d", want.box_hit, got.box_hit);
         fails++;
      end
      if (got.entry_distance !== want.entry_distance) begin
         $error("entry_distance: expected %0d, actual %0d",
                want.entry_distance, got.entry_distance);
         fails++;
      end
   endfunction
endclass

module tb_ray_box_hit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = rbht_pkg::COORD_WIDTH + rbht_pkg::FRAC_BITS + 11;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rbht_pkg::box_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rbht_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   rbht_pkg::csr_index_type csr_index = '0;
   logic [rbht_pkg::COORD_WIDTH-1:0] csr_wdata = '0;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   hit_scoreboard sb = new();

   ray_box_hit_test dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver backpressure
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);

   // result monitor
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);

   task automatic write_reg(rbht_pkg::csr_index_type idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 1'b0;
   endtask

   task automatic send_box(rbht_pkg::box_type b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (req_stall);
      sb.note_box(b);
   endtask

   // drain the pipe so ray registers may change
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.hits_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, rng);
      write_reg(rbht_pkg::CSR_ORIGIN_X, ox);
      write_reg(rbht_pkg::CSR_ORIGIN_Y, oy);
      write_reg(rbht_pkg::CSR_ORIGIN_Z, oz);
      write_reg(rbht_pkg::CSR_DIRECTION_X, dx);
      write_reg(rbht_pkg::CSR_DIRECTION_Y, dy);
      write_reg(rbht_pkg::CSR_DIRECTION_Z, dz);
      write_reg(rbht_pkg::CSR_RANGE, rng);
   endtask

   function automatic rbht_pkg::box_type mk_box(longint c[3], longint h[3]);
      rbht_pkg::box_type b;
      b.box_min_x = 32'(c[0] - h[0]); b.box_max_x = 32'(c[0] + h[0]);
      b.box_min_y = 32'(c[1] - h[1]); b.box_max_y = 32'(c[1] + h[1]);
      b.box_min_z = 32'(c[2] - h[2]); b.box_max_z = 32'(c[2] + h[2]);
      return b;
   endfunction

   function automatic logic [31:0] small_dir();
      case ($urandom_range(5))
         0: return '0;
         1: return 32'sd65536;
         2: return -32'sd65536;
         default: return $urandom_range(0, 1 << 18) - (1 << 17);
      endcase
   endfunction

   // boxes mostly placed near points along the ray, some pure noise
   function automatic rbht_pkg::box_type rand_box();
      longint c[3], h[3];
      longint t;
      rbht_pkg::box_type b;
      if ($urandom_range(4) == 0) begin
         b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         return b;
      end
      t = longint'($urandom_range(0, 1 << 22)) - (1 << 19);
      for (int a = 0; a < 3; a++) begin
         c[a] = sb.org[a] + ((t * sb.dir[a]) >>> 16)
                + longint'($urandom_range(0, 1 << 17)) - (1 << 16);
         h[a] = longint'($urandom_range(0, 1 << ($urandom_range(4, 19))));
         if ($urandom_range(9) == 0) h[a] = -h[a];   // inverted on this axis
         if (c[a] > 64'sh7000_0000 || c[a] < -64'sh7000_0000) c[a] = 0;
      end
      return mk_box(c, h);
   endfunction

   task automatic rand_ray();
      logic [31:0] v[7];
      if ($urandom_range(3) == 0) begin
         foreach (v[i]) v[i] = $urandom;
         if ($urandom_range(1)) v[6] = 32'h7FFF_FFFF;
      end else begin
         for (int i = 0; i < 3; i++) v[i] = $urandom_range(0, 1 << 21) - (1 << 20);
         for (int i = 3; i < 6; i++) v[i] = small_dir();
         v[6] = $urandom_range(2) == 0 ? $urandom_range(0, 1 << 22) : 32'hFFFF_FFFF;
      end
      set_ray(v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
      write_reg(rbht_pkg::csr_index_type'(7), $urandom);   // unused index, ignored
   endtask

   initial begin
      longint c[3], h[3];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default ray along +x
      send_box({6{32'sh7FFF_FFFF}});
      send_box({6{32'sh8000_0000}});
      send_box({32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
      c = '{65536 * 5, 0, 0}; h = '{65536, 65536, 65536};
      send_box(mk_box(c, h));                          // hit ahead
      c = '{-65536 * 5, 0, 0};
      send_box(mk_box(c, h));                          // box behind
      c = '{65536 * 5, 0, 0}; h = '{-65536, 65536, 65536};
      send_box(mk_box(c, h));                          // inverted box
      c = '{65536 * 5, 65536 * 3, 0}; h = '{65536, 65536, 65536};
      send_box(mk_box(c, h));                          // off to the side
      drain();

      // directed: short range rejects, negative diagonal, zero numerators
      set_ray(32'sh0001_0000, -32'sh0002_0000, 32'sh0, -32'sh0001_0000,
              32'sh0000_8000, 32'sh0001_0000, 32'h0002_0000);
      c = '{-65536 * 4, -65536 * 5 / 2 - 65536 * 0, 65536 * 5};
      h = '{65536, 65536, 65536};
      send_box(mk_box(c, h));
      c = '{0, -65536, 65536};
      send_box(mk_box(c, h));
      send_box({32'sh0001_0000, 32'sh0001_0000, -32'sh0002_0000, -32'sh0002_0000,
                32'sh0, 32'sh0});
      send_box({6{32'sh0}});
      drain();
      set_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'h0);
      send_box({6{32'sh7FFF_FFFF}});
      send_box({6{32'sh8000_0000}});
      send_box({32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
      send_box({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
      drain();
      set_ray(32'sh8000_0000, 32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh0, -32'sh0000_0001, 32'h7FFF_FFFF);
      send_box({32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
      send_box({6{32'sh0}});
      drain();

      // random: 12 ray setups, idling profile changes by thirds
      for (int seg = 0; seg < 12; seg++) begin
         tx_idle_pct = (seg < 4) ? 18 : (seg < 8) ? 55 : 0;
         rx_idle_pct = (seg < 4) ? 55 : (seg < 8) ? 18 : 0;
         rand_ray();
         for (int n = 0; n < 120; n++) begin
            if (n == 60 && seg == 5)
               while (sb.hits_due.size() != 0) begin  // hold off until drained
                  req_valid <= 1'b0;
                  @(posedge clock);
               end
            send_box(rand_box());
         end
         drain();
      end

      if (sb.fails == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end
endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/rbht_pkg.sv
rtl/rbht_slab_div.sv
rtl/ray_box_hit_test.sv
dv/tb_ray_box_hit_test.sv
